// ===== hw/rtl/multichannel_ring_sample_buffer_top_macros.svh =====
// Assertion macros for the multichannel ring sample buffer.
// Used by the top level only; no other dependencies.
`ifndef MULTICHANNEL_RING_SAMPLE_BUFFER_TOP_MACROS_SVH
`define MULTICHANNEL_RING_SAMPLE_BUFFER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define RSB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define RSB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/rsb_pkg.sv =====
// Shared types and fixed constants of the multichannel ring sample buffer.
// No dependencies; imported by the front end, queue, back end and top level.
package rsb_pkg;

    // Fixed field widths of the item and result ports
    localparam int CMD_W       = 2;
    localparam int CHAN_W      = 3;
    localparam int OFFSET_W    = 10;
    localparam int SAMPLE_W    = 32;
    localparam int COUNT_W     = 10;
    localparam int POS_W       = 10;
    localparam int CFG_W       = 11;
    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    // Depth of the queue between front and back end
    localparam int QUEUE_DEPTH = 2;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_SNAP  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    // Classified item as it travels through the queue
    typedef struct packed {
        t_op                 op;
        logic                chan_ok;
        logic [CHAN_W-1:0]   channel;
        logic [OFFSET_W-1:0] offset;
        logic [SAMPLE_W-1:0] sample;
    } t_item;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        BS_IDLE,
        BS_EXEC,
        BS_STATUS,
        BS_MOD,
        BS_REPORT
    } t_bstate;

    // Back-end status seen by the top level
    typedef struct packed {
        logic idle;
        logic in_exec;
    } t_back_stat;

endpackage

// ===== hw/rtl/rsb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rsb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; hold data between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/rsb_rem.sv =====
// Bit-serial remainder unit: value modulo ring length, one bit per cycle.
// Depends on nothing but its parameters.
module rsb_rem #(
    parameter int VAL_W = 10,
    parameter int LEN_W = 11
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [VAL_W-1:0] i_value,
    input  logic [LEN_W-1:0] i_len,
    output logic             o_done,
    output logic [VAL_W-1:0] o_rem
);

    localparam int RW    = VAL_W + 1;
    localparam int CNT_W = $clog2(VAL_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [VAL_W-1:0] r_val;
    logic [RW-1:0]    r_rem;
    logic [RW-1:0]    shifted;
    logic [RW-1:0]    n_rem;

    // One restoring step: bring in the next bit, subtract length if it fits
    always_comb begin
        shifted = {r_rem[VAL_W-1:0], r_val[VAL_W-1]};
        n_rem   = (shifted >= RW'(i_len)) ? shifted - RW'(i_len) : shifted;
    end

    // Step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(VAL_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Dividend and partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val <= i_value;
            r_rem <= '0;
        end else if (r_busy) begin
            r_val <= r_val << 1;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[VAL_W-1:0];

endmodule

// ===== hw/rtl/rsb_queue.sv =====
// Short item queue between the front and back ends.
// Depends on rsb_pkg for the item type and depth.
module rsb_queue
    import rsb_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_full,
    output logic  o_empty
);

    localparam int QA_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

    t_item            r_buf [QUEUE_DEPTH];
    logic [QA_W-1:0]  r_wr;
    logic [QA_W-1:0]  r_rd;
    logic [QC_W-1:0]  r_cnt;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == QA_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + QA_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == QA_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + QA_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + QC_W'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - QC_W'(1);
            end
        end
    end

    // Store items
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr] <= i_item;
        end
    end

    assign o_item  = r_buf[r_rd];
    assign o_full  = (r_cnt == QC_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);

endmodule

// ===== hw/rtl/rsb_front.sv =====
// Front end: accepts items, decodes the command, checks the channel, clamps the offset.
// Depends on rsb_pkg for the item type and field widths.
module rsb_front
    import rsb_pkg::*;
#(
    parameter int CHANNELS = 8,
    parameter int LEN_W    = 11
) (
    input  logic                i_start,
    input  logic                i_q_full,
    input  logic [LEN_W-1:0]    i_len,
    input  logic [CMD_W-1:0]    i_cmd,
    input  logic [CHAN_W-1:0]   i_channel,
    input  logic [OFFSET_W-1:0] i_offset,
    input  logic [SAMPLE_W-1:0] i_sample_value,
    output logic                o_busy,
    output logic                o_push,
    output t_item               o_item
);

    localparam int OW = (LEN_W > OFFSET_W) ? LEN_W : OFFSET_W;

    logic [OW-1:0] off_ext;
    logic [OW-1:0] off_lim;
    logic [OW-1:0] off_clamp;
    t_op           op;

    // Decode command
    always_comb begin
        case (i_cmd)
            OP_WRITE: op = OP_WRITE;
            OP_READ:  op = OP_READ;
            OP_SNAP:  op = OP_SNAP;
            default:  op = OP_NOP;
        endcase
    end

    // Clamp offset to length minus one
    always_comb begin
        off_ext   = OW'(i_offset);
        off_lim   = OW'(i_len) - OW'(1);
        off_clamp = (off_ext > off_lim) ? off_lim : off_ext;
    end

    // Build the classified item
    always_comb begin
        o_item.op      = op;
        o_item.chan_ok = (32'(i_channel) < 32'(CHANNELS));
        o_item.channel = i_channel;
        o_item.offset  = OFFSET_W'(off_clamp);
        o_item.sample  = i_sample_value;
    end

    assign o_busy = i_q_full;
    assign o_push = i_start && !i_q_full;

endmodule

// ===== hw/rtl/rsb_back.sv =====
// Back end: pointer state, sample store, remainder units and result register.
// Depends on rsb_pkg, rsb_ram and rsb_rem.
module rsb_back
    import rsb_pkg::*;
#(
    parameter int CHANNELS    = 8,
    parameter int RING_DEPTH  = 1024,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [$clog2(RING_DEPTH + 1)-1:0]  i_len,
    input  logic                               i_q_valid,
    input  t_item                              i_item,
    output logic                               o_pop,
    output t_back_stat                         o_stat,
    output logic                               o_strobe,
    output logic [SAMPLE_W-1:0]                o_read_sample,
    output logic [COUNT_W-1:0]                 o_pending_count,
    output logic [POS_W-1:0]                   o_read_position,
    output logic                               o_samples_ready
);

    localparam int PTR_W     = $clog2(RING_DEPTH);
    localparam int LEN_W     = $clog2(RING_DEPTH + 1);
    localparam int CW        = PTR_W + 2;
    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int MEM_DEPTH = CHANNELS * RING_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    t_bstate             r_state;
    t_bstate             n_state;
    t_item               r_item;
    logic [PTR_W-1:0]    r_wp [CHANNELS];
    logic [PTR_W-1:0]    r_rp [CHANNELS];
    logic                r_ready;
    logic                r_strobe;
    logic [SAMPLE_W-1:0] r_sample;
    logic [COUNT_W-1:0]  r_count;
    logic [POS_W-1:0]    r_rpos;
    logic                r_flag;

    logic                pop;
    logic                mem_we;
    logic                mem_re;
    logic                ptr_we;
    logic                ready_set;
    logic                snap;
    logic                rem_start;
    logic                emit;
    logic                use_rem;

    logic [CH_W-1:0]        ch_idx;
    logic [PTR_W-1:0]       cur_wp;
    logic [PTR_W-1:0]       cur_rp;
    logic [CW-1:0]          len_c;
    logic [CW-1:0]          wp_inc;
    logic [PTR_W-1:0]       wp_next;
    logic [CW-1:0]          rd_sum;
    logic [PTR_W-1:0]       rd_idx;
    logic                   fast;
    logic [ADDR_W-1:0]      base;
    logic [ADDR_W-1:0]      waddr;
    logic [ADDR_W-1:0]      raddr;
    logic [SAMPLE_BITS-1:0] mem_rdata;
    logic                   rem_w_done;
    logic                   rem_r_done;
    logic [PTR_W-1:0]       rem_w;
    logic [PTR_W-1:0]       rem_r;
    logic [CW-1:0]          cnt_a;
    logic [CW-1:0]          cnt_b;
    logic [CW-1:0]          cnt_diff;

    // Addressed channel's pointers
    always_comb begin
        ch_idx = CH_W'(r_item.channel);
        cur_wp = r_item.chan_ok ? r_wp[ch_idx] : '0;
        cur_rp = r_item.chan_ok ? r_rp[ch_idx] : '0;
        len_c  = CW'(i_len);
    end

    // Write pointer advance with wrap at the ring length
    always_comb begin
        wp_inc  = CW'(cur_wp) + CW'(1);
        wp_next = (wp_inc >= len_c) ? '0 : wp_inc[PTR_W-1:0];
    end

    // Read slot: read pointer plus offset, wrapped once
    always_comb begin
        rd_sum = CW'(cur_rp) + CW'(r_item.offset);
        if (rd_sum >= len_c) begin
            rd_sum = rd_sum - len_c;
        end
        rd_idx = rd_sum[PTR_W-1:0];
    end

    // Store addresses
    always_comb begin
        base  = ADDR_W'(ch_idx) * ADDR_W'(RING_DEPTH);
        waddr = base + ADDR_W'(cur_wp);
        raddr = base + ADDR_W'(rd_idx);
    end

    // Pointers inside the ring need no remainder pass
    assign fast = (CW'(cur_wp) < len_c) && (CW'(cur_rp) < len_c);

    // Pending count from the pointers, reduced ones after a remainder pass
    always_comb begin
        cnt_a    = use_rem ? CW'(rem_w) : CW'(cur_wp);
        cnt_b    = use_rem ? CW'(rem_r) : CW'(cur_rp);
        cnt_diff = (cnt_a >= cnt_b) ? cnt_a - cnt_b : cnt_a + len_c - cnt_b;
    end

    // Next state
    always_comb begin
        case (r_state)
            BS_IDLE:   n_state = i_q_valid ? BS_EXEC : BS_IDLE;
            BS_EXEC:   n_state = BS_STATUS;
            BS_STATUS: begin
                if (!fast) begin
                    n_state = BS_MOD;
                end else begin
                    n_state = i_q_valid ? BS_EXEC : BS_IDLE;
                end
            end
            BS_MOD:    n_state = (rem_w_done && rem_r_done) ? BS_REPORT : BS_MOD;
            BS_REPORT: n_state = i_q_valid ? BS_EXEC : BS_IDLE;
            default:   n_state = BS_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        pop       = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        ptr_we    = 1'b0;
        ready_set = 1'b0;
        snap      = 1'b0;
        rem_start = 1'b0;
        emit      = 1'b0;
        use_rem   = 1'b0;
        case (r_state)
            BS_IDLE: begin
                pop = i_q_valid;
            end
            BS_EXEC: begin
                case (r_item.op)
                    OP_WRITE: begin
                        mem_we    = r_item.chan_ok;
                        ptr_we    = r_item.chan_ok;
                        ready_set = r_item.chan_ok;
                    end
                    OP_READ:  mem_re = r_item.chan_ok;
                    OP_SNAP:  snap   = 1'b1;
                    default:  ;
                endcase
            end
            BS_STATUS: begin
                if (fast) begin
                    emit = 1'b1;
                    pop  = i_q_valid;
                end else begin
                    rem_start = 1'b1;
                end
            end
            BS_REPORT: begin
                emit    = 1'b1;
                use_rem = 1'b1;
                pop     = i_q_valid;
            end
            default: ;
        endcase
    end

    // Control state and pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BS_IDLE;
            r_ready  <= 1'b0;
            r_strobe <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_wp[c] <= '0;
                r_rp[c] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_strobe <= emit;
            if (ptr_we) begin
                r_wp[ch_idx] <= wp_next;
            end
            if (ready_set) begin
                r_ready <= 1'b1;
            end
            if (snap) begin
                r_ready <= 1'b0;
                for (int c = 0; c < CHANNELS; c++) begin
                    r_rp[c] <= r_wp[c];
                end
            end
        end
    end

    // Current item and result payload
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_item <= i_item;
        end
        if (emit) begin
            r_sample <= (r_item.op == OP_READ && r_item.chan_ok)
                        ? SAMPLE_W'(mem_rdata) : '0;
            r_count  <= r_item.chan_ok ? COUNT_W'(cnt_diff) : '0;
            r_rpos   <= r_item.chan_ok ? POS_W'(cur_rp) : '0;
            r_flag   <= r_ready;
        end
    end

    // Sample store
    rsb_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MEM_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (waddr),
        .i_wdata (SAMPLE_BITS'(r_item.sample)),
        .i_re    (mem_re),
        .i_raddr (raddr),
        .o_rdata (mem_rdata)
    );

    // Reduce both pointers modulo the length side by side
    rsb_rem #(
        .VAL_W (PTR_W),
        .LEN_W (LEN_W)
    ) u_rem_w (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rem_start),
        .i_value (cur_wp),
        .i_len   (i_len),
        .o_done  (rem_w_done),
        .o_rem   (rem_w)
    );

    rsb_rem #(
        .VAL_W (PTR_W),
        .LEN_W (LEN_W)
    ) u_rem_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rem_start),
        .i_value (cur_rp),
        .i_len   (i_len),
        .o_done  (rem_r_done),
        .o_rem   (rem_r)
    );

    assign o_pop           = pop;
    assign o_stat.idle     = (r_state == BS_IDLE);
    assign o_stat.in_exec  = (r_state == BS_EXEC);
    assign o_strobe        = r_strobe;
    assign o_read_sample   = r_sample;
    assign o_pending_count = r_count;
    assign o_read_position = r_rpos;
    assign o_samples_ready = r_flag;

endmodule

// ===== hw/rtl/multichannel_ring_sample_buffer_top.sv =====
// Top level of the multichannel ring sample buffer: length register, front end,
// queue and back end. Depends on rsb_pkg, rsb_front, rsb_queue, rsb_back and the macros header.
//
// Each channel owns a ring of RING_DEPTH sample slots, of which the first
// buffer_length are in use. An item is taken when start is high and busy is
// low; busy rises only when the two-entry item queue is full. Every item gives
// one result, shown for a single cycle with o_result_valid; the receiver cannot
// hold it off, so it must take every result as it comes. The back end works
// through each item in two steps (EXEC to access the sample store and pointers,
// STATUS to read back status) and takes the next item only when it is through
// with the last one; the result is registered from STATUS. After a length change
// that leaves a pointer at or beyond the new length, the pending count of that
// item goes through a bit-serial remainder in state MOD and is shown from state
// REPORT. Write buffer_length only while no item is outstanding.
`include "multichannel_ring_sample_buffer_top_macros.svh"

module multichannel_ring_sample_buffer_top
    import rsb_pkg::*;
#(
    parameter int CHANNELS    = 8,
    parameter int RING_DEPTH  = 1024,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CFG_W-1:0]    i_cfg_wdata,
    input  logic                start,
    output logic                busy,
    input  logic [CMD_W-1:0]    i_cmd,
    input  logic [CHAN_W-1:0]   i_channel,
    input  logic [OFFSET_W-1:0] i_offset,
    input  logic [SAMPLE_W-1:0] i_sample_value,
    output logic                o_result_valid,
    output logic [SAMPLE_W-1:0] o_read_sample,
    output logic [COUNT_W-1:0]  o_pending_count,
    output logic [POS_W-1:0]    o_read_position,
    output logic                o_samples_ready
);

    localparam int LEN_W = $clog2(RING_DEPTH + 1);
    localparam int LCW   = (LEN_W > CFG_W) ? LEN_W : CFG_W;

    logic [CFG_W-1:0] r_buffer_length;
    logic [LCW-1:0]   len_ext;
    logic [LEN_W-1:0] ring_len;
    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    t_item            front_item;
    t_item            q_item;
    t_back_stat       back_stat;

    // Length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_length <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_buffer_length <= i_cfg_wdata;
        end
    end

    // Effective length: zero acts as one, clamp to the ring depth
    always_comb begin
        len_ext = LCW'(r_buffer_length);
        if (r_buffer_length == '0) begin
            ring_len = LEN_W'(1);
        end else if (len_ext > LCW'(RING_DEPTH)) begin
            ring_len = LEN_W'(RING_DEPTH);
        end else begin
            ring_len = LEN_W'(len_ext);
        end
    end

    rsb_front #(
        .CHANNELS (CHANNELS),
        .LEN_W    (LEN_W)
    ) u_front (
        .i_start        (start),
        .i_q_full       (q_full),
        .i_len          (ring_len),
        .i_cmd          (i_cmd),
        .i_channel      (i_channel),
        .i_offset       (i_offset),
        .i_sample_value (i_sample_value),
        .o_busy         (busy),
        .o_push         (q_push),
        .o_item         (front_item)
    );

    rsb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (front_item),
        .i_pop   (q_pop),
        .o_item  (q_item),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    rsb_back #(
        .CHANNELS    (CHANNELS),
        .RING_DEPTH  (RING_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_len           (ring_len),
        .i_q_valid       (!q_empty),
        .i_item          (q_item),
        .o_pop           (q_pop),
        .o_stat          (back_stat),
        .o_strobe        (o_result_valid),
        .o_read_sample   (o_read_sample),
        .o_pending_count (o_pending_count),
        .o_read_position (o_read_position),
        .o_samples_ready (o_samples_ready)
    );

    // Checks across front, queue and back end
    `RSB_ASSERT_IMP(a_pop_nonempty, i_clk, i_rst_n, q_pop, !q_empty, "pop from empty queue")
    `RSB_ASSERT_NEXT(a_pop_exec, i_clk, i_rst_n, q_pop, back_stat.in_exec, "popped item not executed")
    `RSB_ASSERT_NEXT(a_strobe_gap, i_clk, i_rst_n, o_result_valid, !o_result_valid, "results too close")
    `RSB_ASSERT_NEXT(a_quiet_idle, i_clk, i_rst_n, q_empty && back_stat.idle, !o_result_valid, "result with no item")

endmodule
